// File: hw/rtl/psbo_pkg.sv
package psbo_pkg;

    localparam int PIX_W   = 8;
    localparam int CMD_W   = 2;
    localparam int BOX_W   = 13;
    localparam int FRAME_W = 13;
    localparam int CMP_W   = 15;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BOX   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
    localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;

    typedef struct packed {
        logic signed [BOX_W-1:0] left;
        logic signed [BOX_W-1:0] top;
        logic [BOX_W-1:0]        width;
        logic [BOX_W-1:0]        height;
    } t_box;

    typedef struct packed {
        logic signed [CMP_W-1:0] x;
        logic signed [CMP_W-1:0] y;
        logic                    eol;
        logic                    eof;
    } t_pos;

endpackage

// File: hw/rtl/psbo_box_hit.sv
module psbo_box_hit (
    input  psbo_pkg::t_box                     i_box,
    input  logic signed [psbo_pkg::CMP_W-1:0]  i_x,
    input  logic signed [psbo_pkg::CMP_W-1:0]  i_y,
    output logic                               o_hit
);

    logic signed [psbo_pkg::CMP_W-1:0] lft, top, rgt, bot;
    logic in_cols, in_rows, row_edge, col_edge;

    always_comb begin
        lft = psbo_pkg::CMP_W'(i_box.left);
        top = psbo_pkg::CMP_W'(i_box.top);
        rgt = lft + signed'(psbo_pkg::CMP_W'(i_box.width));
        bot = top + signed'(psbo_pkg::CMP_W'(i_box.height));

        in_cols  = (i_x >= lft) && (i_x < rgt);
        in_rows  = (i_y >= top) && (i_y < bot);
        row_edge = (i_y == top) || (i_y == top + 15'sd1) ||
                   (i_y == bot - 15'sd1) || (i_y == bot - 15'sd2);
        col_edge = (i_x == lft) || (i_x == lft + 15'sd1) ||
                   (i_x == rgt - 15'sd1) || (i_x == rgt - 15'sd2);

        o_hit = (row_edge && in_cols) || (col_edge && in_rows);
    end

endmodule

// File: hw/rtl/psbo_box_table.sv
module psbo_box_table #(
    parameter int MAX_BOXES = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr,
    input  logic                               i_clr,
    input  psbo_pkg::t_box                     i_box,
    input  logic signed [psbo_pkg::CMP_W-1:0]  i_x,
    input  logic signed [psbo_pkg::CMP_W-1:0]  i_y,
    output logic                               o_hit
);

    localparam int CNT_W = $clog2(MAX_BOXES + 1);

    logic [CNT_W-1:0]     r_count, n_count;
    psbo_pkg::t_box       r_box [MAX_BOXES];
    logic [MAX_BOXES-1:0] hit_vec;
    logic [MAX_BOXES-1:0] valid_vec;

    always_comb begin
        n_count = r_count;
        if (i_clr) begin
            n_count = '0;
        end else if (i_wr && (r_count < CNT_W'(MAX_BOXES))) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    for (genvar i = 0; i < MAX_BOXES; i++) begin : g_entry
        always_ff @(posedge i_clk) begin
            if (i_wr && (r_count == CNT_W'(i))) begin
                r_box[i] <= i_box;
            end
        end

        assign valid_vec[i] = (r_count > CNT_W'(i));

        psbo_box_hit u_hit (
            .i_box (r_box[i]),
            .i_x   (i_x),
            .i_y   (i_y),
            .o_hit (hit_vec[i])
        );
    end

    assign o_hit = |(hit_vec & valid_vec);

endmodule

// File: hw/rtl/psbo_raster.sv
module psbo_raster #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic [psbo_pkg::FRAME_W-1:0]  i_frame_width,
    input  logic [psbo_pkg::FRAME_W-1:0]  i_frame_height,
    output psbo_pkg::t_pos                o_pos
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = psbo_pkg::FRAME_W + 1;
    localparam logic [EW-1:0] DIM = EW'(MAX_DIM);

    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [EW-1:0] w_ext, h_ext, last_w, last_h;
    logic          eol, eof;

    always_comb begin
        w_ext = EW'(i_frame_width);
        h_ext = EW'(i_frame_height);

        if (w_ext == '0) begin
            last_w = '0;
        end else if (w_ext > DIM) begin
            last_w = DIM - EW'(1);
        end else begin
            last_w = w_ext - EW'(1);
        end

        if (h_ext == '0) begin
            last_h = '0;
        end else if (h_ext > DIM) begin
            last_h = DIM - EW'(1);
        end else begin
            last_h = h_ext - EW'(1);
        end

        eol = (EW'(r_col) >= last_w);
        eof = eol && (EW'(r_row) >= last_h);

        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (eol) begin
                n_col = '0;
                n_row = eof ? '0 : r_row + CW'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.x   = signed'(psbo_pkg::CMP_W'(r_col));
    assign o_pos.y   = signed'(psbo_pkg::CMP_W'(r_row));
    assign o_pos.eol = eol;
    assign o_pos.eof = eof;

endmodule

// File: hw/rtl/pixel_swizzle_box_outline_overlay_unit.sv
// Box outline overlay on a BGR pixel stream, giving RGB pixels. Each word carries a command:
// a pixel, a box to add to the table, or a table clear; only pixels produce an output word.
// A pixel on the two-pixel outline of any stored box comes out pure green. One word is taken per
// clock while o_ready is high; a pixel's output word appears in the cycle after it is taken, set
// by the single result register after the parallel compare against all MAX_BOXES table entries.
// Frame width and height come from the config port; write them only while the block is idle.
module pixel_swizzle_box_outline_overlay_unit #(
    parameter int MAX_BOXES = 8,
    parameter int MAX_DIM   = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_cfg_we,
    input  logic [psbo_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [psbo_pkg::FRAME_W-1:0]      i_cfg_data,

    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [psbo_pkg::CMD_W-1:0]        i_cmd,
    input  logic [psbo_pkg::PIX_W-1:0]        i_pix_blue,
    input  logic [psbo_pkg::PIX_W-1:0]        i_pix_green,
    input  logic [psbo_pkg::PIX_W-1:0]        i_pix_red,
    input  logic signed [psbo_pkg::BOX_W-1:0] i_box_left,
    input  logic signed [psbo_pkg::BOX_W-1:0] i_box_top,
    input  logic [psbo_pkg::BOX_W-1:0]        i_box_width,
    input  logic [psbo_pkg::BOX_W-1:0]        i_box_height,

    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [psbo_pkg::PIX_W-1:0]        o_out_red,
    output logic [psbo_pkg::PIX_W-1:0]        o_out_green,
    output logic [psbo_pkg::PIX_W-1:0]        o_out_blue,
    output logic                              o_on_outline,
    output logic                              o_end_of_line,
    output logic                              o_end_of_frame
);

    logic [psbo_pkg::FRAME_W-1:0] r_frame_width, r_frame_height;
    logic                         acc, acc_pix, acc_box, acc_clr;
    logic                         hit;
    psbo_pkg::t_box               box_in;
    psbo_pkg::t_pos               pos;

    logic                         r_valid;
    logic [psbo_pkg::PIX_W-1:0]   r_red, r_green, r_blue;
    logic                         r_hit, r_eol, r_eof;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= psbo_pkg::FRAME_WIDTH_RST;
            r_frame_height <= psbo_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                psbo_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                psbo_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign acc     = i_valid && o_ready;
    assign acc_pix = acc && (i_cmd == psbo_pkg::CMD_PIXEL);
    assign acc_box = acc && (i_cmd == psbo_pkg::CMD_BOX);
    assign acc_clr = acc && (i_cmd == psbo_pkg::CMD_CLEAR);

    assign box_in.left   = i_box_left;
    assign box_in.top    = i_box_top;
    assign box_in.width  = i_box_width;
    assign box_in.height = i_box_height;

    psbo_raster #(
        .MAX_DIM (MAX_DIM)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (acc_pix),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_pos          (pos)
    );

    psbo_box_table #(
        .MAX_BOXES (MAX_BOXES)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (acc_box),
        .i_clr   (acc_clr),
        .i_box   (box_in),
        .i_x     (pos.x),
        .i_y     (pos.y),
        .o_hit   (hit)
    );

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc_pix) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_pix) begin
            r_red   <= hit ? psbo_pkg::PIX_ZERO : i_pix_red;
            r_green <= hit ? psbo_pkg::PIX_FULL : i_pix_green;
            r_blue  <= hit ? psbo_pkg::PIX_ZERO : i_pix_blue;
            r_hit   <= hit;
            r_eol   <= pos.eol;
            r_eof   <= pos.eof;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_red      = r_red;
    assign o_out_green    = r_green;
    assign o_out_blue     = r_blue;
    assign o_on_outline   = r_hit;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

    a_clear_then_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_clr ##1 acc_pix |=> !r_hit)
        else $error("outline hit right after table clear");

    a_eof_implies_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_eof |-> r_eol)
        else $error("end of frame without end of line");

    a_outline_green: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pix && hit |=> r_green == psbo_pkg::PIX_FULL && r_red == psbo_pkg::PIX_ZERO
                           && r_blue == psbo_pkg::PIX_ZERO)
        else $error("outline pixel not pure green");

    a_eol_wraps_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_pix && pos.eol |=> pos.x == '0)
        else $error("column did not wrap after end of line");

endmodule
